// ----- hw/rtl/swcr_pkg.sv -----
// ----------------------------------------------------------------------------
// swcr_pkg
// Shared types, codes and microcode ROM for the coverage run generator.
// ----------------------------------------------------------------------------
package swcr_pkg;

  // fixed field widths
  localparam int OUT_POS_W   = 32;
  localparam int COV_W       = 6;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 72;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int HW_W        = 16;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROM_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_ZERO  = 2'd2;

  // input kinds (tuser)
  localparam logic ACT_SITE   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // datapath operations
  typedef enum logic [2:0] {
    UOP_WAIT,   // wait for an input word
    UOP_CALC,   // window start / end
    UOP_NOP,    // let the FIFO read data settle
    UOP_TEST,   // decide whether the head closer pops
    UOP_POP,    // pop a closer, maybe emit a run
    UOP_GAP,    // run up to window start, or final zero run
    UOP_END     // flush last run, push closer or clear
  } uop_t;

  // jump conditions
  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_IDLE,
    JMP_NO_POP
  } jcond_t;

  typedef logic [2:0] upc_t;

  localparam upc_t PC_WAIT  = 3'd0;
  localparam upc_t PC_CALC  = 3'd1;
  localparam upc_t PC_FETCH = 3'd2;
  localparam upc_t PC_TEST  = 3'd3;
  localparam upc_t PC_POP   = 3'd4;
  localparam upc_t PC_GAP   = 3'd5;
  localparam upc_t PC_END   = 3'd6;

  typedef struct packed {
    uop_t   op;
    jcond_t jmp;
    upc_t   target;
  } uword_t;

  // one run headed for the output buffer
  typedef struct packed {
    logic [OUT_POS_W-1:0] run_start;
    logic [OUT_POS_W-1:0] run_end;
    logic [COV_W-1:0]     coverage;
  } run_t;

  // sequencer -> output buffer
  typedef struct packed {
    logic push;   // new run
    logic flush;  // item done, pending run is the last
    logic ovf;    // overflow flag for runs leaving now
  } obuf_ctl_t;

  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    case (pc)
      PC_WAIT:  w = '{op: UOP_WAIT, jmp: JMP_IDLE,   target: PC_WAIT};
      PC_CALC:  w = '{op: UOP_CALC, jmp: JMP_NONE,   target: PC_WAIT};
      PC_FETCH: w = '{op: UOP_NOP,  jmp: JMP_NONE,   target: PC_WAIT};
      PC_TEST:  w = '{op: UOP_TEST, jmp: JMP_NO_POP, target: PC_GAP};
      PC_POP:   w = '{op: UOP_POP,  jmp: JMP_ALWAYS, target: PC_FETCH};
      PC_GAP:   w = '{op: UOP_GAP,  jmp: JMP_NONE,   target: PC_WAIT};
      PC_END:   w = '{op: UOP_END,  jmp: JMP_ALWAYS, target: PC_WAIT};
      default:  w = '{op: UOP_WAIT, jmp: JMP_ALWAYS, target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/swcr_outbuf.sv -----
// ----------------------------------------------------------------------------
// swcr_outbuf
// One-run hold stage plus output register; marks the last run of an item.
// ----------------------------------------------------------------------------
module swcr_outbuf import swcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  obuf_ctl_t              ctl,
  input  run_t                   run,
  output logic                   stall,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // run_start, run_end, coverage, pad
  output logic                   m_axis_tlast,
  output logic [0:0]             m_axis_tuser   // queue_overflow
);

  logic pend_valid;
  run_t pend;
  run_t out_run;
  logic out_last;
  logic out_ovf;
  logic out_free;
  logic send;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign stall    = (ctl.push || ctl.flush) && pend_valid && !out_free;
  assign send     = (ctl.push || ctl.flush) && pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (send) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (ctl.push && !stall) begin
        pend_valid <= 1'b1;
      end else if (ctl.flush && !stall) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_run  <= pend;
      out_last <= ctl.flush;
      out_ovf  <= ctl.ovf;
    end
    if (ctl.push && !stall) begin
      pend <= run;
    end
  end

  assign m_axis_tdata = {2'b00, out_run.coverage, out_run.run_end, out_run.run_start};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_ovf;

endmodule

// ----- hw/rtl/smoothed_site_coverage_runs.sv -----
// ----------------------------------------------------------------------------
// smoothed_site_coverage_runs
// Sliding-window coverage pileup over sorted sites of one chromosome.
// ----------------------------------------------------------------------------
// Each site word (tuser 0) opens a window [max(1, p-half_width), p+half_width+1);
// its end waits in a closer FIFO of QUEUE_DEPTH entries. Runs of constant
// coverage (start, exclusive end, count) come out as window starts and closers
// pass; tlast marks the final run caused by an input word, and a word may cause
// none. A finish word (tuser 1) drains the FIFO, clamps to the chromosome length
// when that is nonzero, and clears the per-chromosome state. tuser on the output
// is the sticky overflow flag (a site dropped on a full FIFO since the last finish).
// A small microcode ROM steps a shared compare/emit datapath: wait, calc, fetch,
// test, then pop, fetch and test again per closer popped around the FIFO's
// registered read port, then gap and end. Output back-pressure adds cycles only
// when the one-run hold stage and the output register are both full. No clearing
// pass: FIFO entries are only read after they were written. Config writes are to
// be made only while no word is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module smoothed_site_coverage_runs import swcr_pkg::*; #(
  parameter int QUEUE_DEPTH   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // site_position
  input  logic [0:0]             s_axis_tuser,   // action
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // run_start, run_end, coverage, pad
  output logic                   m_axis_tlast,   // last
  output logic [0:0]             m_axis_tuser,   // queue_overflow
  // config
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W  = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);
  localparam logic [FILL_W-1:0]        FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]         PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

  // config registers
  logic [HW_W-1:0]      half_width;
  logic [OUT_POS_W-1:0] chrom_len;
  logic                 emit_zero;

  // sequencer
  upc_t   pc;
  upc_t   pc_next;
  uword_t uw;
  logic   jump;
  logic   stall;

  // per-item payload
  logic                     act;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] win_start;
  logic [POSITION_BITS-1:0] win_end;

  // chromosome state
  logic [POSITION_BITS-1:0] run_pos;
  logic [FILL_W-1:0]        open_cnt;
  logic [PTR_W-1:0]         head;
  logic [PTR_W-1:0]         tail;
  logic [FILL_W-1:0]        fill;
  logic                     ovf_flag;

  // closer FIFO storage
  logic [POSITION_BITS-1:0] closer_mem [QUEUE_DEPTH];
  logic [POSITION_BITS-1:0] rd;

  // window math
  logic [POSITION_BITS-1:0] hw_ext;
  logic [POSITION_BITS:0]   e_sum;
  logic [POSITION_BITS-1:0] s_calc;
  logic [POSITION_BITS-1:0] e_calc;

  // emit path
  logic [CMP_W-1:0] em_start;
  logic [CMP_W-1:0] em_end_raw;
  logic [CMP_W-1:0] em_end;
  logic [CMP_W-1:0] em_lim;
  logic [COV_W-1:0] em_cov;
  logic             em_cand;
  logic             lim_on;
  logic             em_keep;
  logic             pop_now;
  logic             push_ok;

  obuf_ctl_t obuf_ctl;
  run_t      obuf_run;

  assign uw            = ucode_rom(pc);
  assign s_axis_tready = (uw.op == UOP_WAIT);

  // head closer pops when it is at or before the new window start (any on finish)
  assign pop_now = (act == ACT_FINISH) ? (fill != '0)
                                       : ((fill != '0) && (rd <= win_start));

  always_comb begin
    case (uw.jmp)
      JMP_NONE:   jump = 1'b0;
      JMP_ALWAYS: jump = 1'b1;
      JMP_IDLE:   jump = !s_axis_tvalid;
      JMP_NO_POP: jump = !pop_now;
      default:    jump = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = uw.target;
    end else begin
      pc_next = 3'(pc + 3'd1);
    end
  end

  // window bounds: start clamps at 1, end saturates at the top position
  assign hw_ext = POSITION_BITS'(half_width);
  assign s_calc = (pos > hw_ext) ? (pos - hw_ext) : POS_ONE;
  assign e_sum  = {1'b0, pos} + (POSITION_BITS + 1)'(half_width) + (POSITION_BITS + 1)'(1);
  assign e_calc = (e_sum > {1'b0, POS_MAX}) ? POS_MAX : e_sum[POSITION_BITS-1:0];

  // candidate run for the current step
  always_comb begin
    em_start   = CMP_W'(run_pos);
    em_end_raw = '0;
    em_lim     = '0;
    em_cov     = COV_W'(open_cnt);
    em_cand    = 1'b0;
    case (uw.op)
      UOP_POP: begin
        em_end_raw = CMP_W'(rd);
        em_lim     = (act == ACT_FINISH) ? CMP_W'(chrom_len) : '0;
        em_cand    = rd > run_pos;
      end
      UOP_GAP: begin
        if (act == ACT_FINISH) begin
          // zero run out to chromosome end
          em_end_raw = CMP_W'(chrom_len);
          em_lim     = CMP_W'(chrom_len);
          em_cov     = '0;
          em_cand    = (chrom_len != '0) && (CMP_W'(run_pos) < CMP_W'(chrom_len));
        end else begin
          em_end_raw = CMP_W'(win_start);
          em_cand    = win_start > run_pos;
        end
      end
      default: begin
        em_cand = 1'b0;
      end
    endcase
  end

  assign lim_on  = (em_lim != '0);
  assign em_end  = (lim_on && (em_end_raw > em_lim)) ? em_lim : em_end_raw;
  assign em_keep = em_cand && (!lim_on || (em_start < em_lim)) && (em_end > em_start)
                   && ((em_cov != '0) || emit_zero);

  // overflow as it will stand after this item; only a site with no pops can
  // find the FIFO still full
  assign obuf_ctl.push  = em_keep;
  assign obuf_ctl.flush = (uw.op == UOP_END);
  assign obuf_ctl.ovf   = ovf_flag || ((act == ACT_SITE) && (fill == FILL_FULL));

  assign obuf_run.run_start = em_start[OUT_POS_W-1:0];
  assign obuf_run.run_end   = em_end[OUT_POS_W-1:0];
  assign obuf_run.coverage  = em_cov;

  assign push_ok = (fill != FILL_FULL);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= PC_WAIT;
      half_width <= HW_W'(25);
      chrom_len  <= '0;
      emit_zero  <= 1'b0;
      run_pos    <= POS_ONE;
      open_cnt   <= '0;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      ovf_flag   <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_WIDTH: half_width <= cfg_data[HW_W-1:0];
          REG_CHROM_SIZE: chrom_len  <= cfg_data[OUT_POS_W-1:0];
          REG_EMIT_ZERO:  emit_zero  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (!stall) begin
        case (uw.op)
          UOP_POP: begin
            head <= (head == PTR_LAST) ? '0 : PTR_W'(head + 1'b1);
            fill <= FILL_W'(fill - 1'b1);
            if (em_cand) begin
              run_pos <= rd;
            end
            if (open_cnt != '0) begin
              open_cnt <= FILL_W'(open_cnt - 1'b1);
            end
          end
          UOP_GAP: begin
            if ((act == ACT_SITE) && em_cand) begin
              run_pos <= win_start;
            end
          end
          UOP_END: begin
            if (act == ACT_FINISH) begin
              run_pos  <= POS_ONE;
              open_cnt <= '0;
              head     <= '0;
              tail     <= '0;
              fill     <= '0;
              ovf_flag <= 1'b0;
            end else if (push_ok) begin
              tail     <= (tail == PTR_LAST) ? '0 : PTR_W'(tail + 1'b1);
              fill     <= FILL_W'(fill + 1'b1);
              open_cnt <= FILL_W'(open_cnt + 1'b1);
            end else begin
              ovf_flag <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act <= s_axis_tuser[0];
      pos <= POSITION_BITS'(s_axis_tdata);
    end
    if (uw.op == UOP_CALC) begin
      win_start <= s_calc;
      win_end   <= e_calc;
    end
  end

  // closer FIFO: one write port, registered read of the head
  always_ff @(posedge clk) begin
    if ((uw.op == UOP_END) && !stall && (act == ACT_SITE) && push_ok) begin
      closer_mem[tail] <= win_end;
    end
    rd <= closer_mem[head];
  end

  swcr_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .ctl           (obuf_ctl),
    .run           (obuf_run),
    .stall         (stall),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- hw/rtl/swcr_checker.sv -----
// ----------------------------------------------------------------------------
// swcr_checker
// Port-level checks for the coverage run generator, bound to the top level.
// ----------------------------------------------------------------------------
module swcr_checker import swcr_pkg::*; #(
  parameter int QUEUE_DEPTH   = 32,
  parameter int POSITION_BITS = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,   // run_start, run_end, coverage, pad
  input logic                   m_axis_tlast,
  input logic [0:0]             m_axis_tuser    // queue_overflow
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // one word at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // runs are never empty
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (POSITION_BITS <= OUT_POS_W) |->
      m_axis_tdata[2*OUT_POS_W-1:OUT_POS_W] > m_axis_tdata[OUT_POS_W-1:0])
    else $error("run end not past run start");

  // coverage bounded by FIFO depth
  a_cov_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[2*OUT_POS_W+COV_W-1:2*OUT_POS_W] <= COV_W'(QUEUE_DEPTH))
    else $error("coverage above queue depth");

endmodule

bind smoothed_site_coverage_runs swcr_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .POSITION_BITS (POSITION_BITS)
) u_swcr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_smoothed_site_coverage_runs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_site_coverage_runs
// Self-checking bench for the sliding-window coverage run generator. Sites and
// finish words go in over the slave stream. Every word is run through a local
// pileup model, and the runs it yields are checked in order against the master
// stream. Register settings change only while the block is idle. Both stream
// sides idle at random in several phases, with two long output holds.
// ----------------------------------------------------------------------------
module tb_smoothed_site_coverage_runs;
  import swcr_pkg::*;

  localparam int CLOSER_DEPTH  = 32;
  localparam int SETTLE_CYCLES = 200;   // covers the worst word, 32 closer pops, plus output stages
  localparam int HOLD_CYCLES   = 600;   // long output hold, fills the block
  localparam int QUIET_LIMIT   = 4000;  // cycles with no word moving on either side
  localparam int RANDOM_WORDS  = 46;    // per register setting, 8 settings

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;    // site_position
  logic [0:0]             s_axis_tuser = '0;    // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;         // run_start, run_end, coverage, pad
  logic                   m_axis_tlast;         // last
  logic [0:0]             m_axis_tuser;         // queue_overflow
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // one expected run on the output stream
  typedef struct packed {
    logic [31:0] run_start;
    logic [31:0] run_end;
    logic [5:0]  coverage;
    logic        last;
    logic        ovf;
  } run_rec_t;

  // --------------------------------------------------------------------------
  // Pileup model: tracks open windows and the closer queue, turns each input
  // word into the list of constant-coverage runs it releases.
  // --------------------------------------------------------------------------
  class pileup_scoreboard;
    logic [15:0] half_width;
    logic [31:0] chrom_len;
    logic        emit_zero;
    logic [31:0] run_pos;
    logic [5:0]  open_cnt;
    logic [31:0] closers[$];
    logic        ovf_flag;
    run_rec_t    batch[$];
    run_rec_t    runs_due[$];
    int          errors, words, runs_seen, ovf_runs;

    function new();
      half_width = 16'd25;
      chrom_len  = '0;
      emit_zero  = 1'b0;
      ovf_flag   = 1'b0;
      errors = 0; words = 0; runs_seen = 0; ovf_runs = 0;
      clear_chrom();
    endfunction

    function void clear_chrom();
      run_pos  = 32'd1;
      open_cnt = '0;
      closers.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_HALF_WIDTH: half_width = val[15:0];
        REG_CHROM_SIZE: chrom_len  = val;
        REG_EMIT_ZERO:  emit_zero  = val[0];
        default: ;
      endcase
    endfunction

    // limit 0: no clamp
    function void add_run(logic [31:0] start, logic [31:0] stop, logic [5:0] cov,
                          logic [31:0] limit);
      run_rec_t r;
      if (limit != 0) begin
        if (start >= limit) return;
        if (stop > limit) stop = limit;
      end
      if (stop <= start) return;
      if (cov == 0 && !emit_zero) return;
      r = '{run_start: start, run_end: stop, coverage: cov, last: 1'b0, ovf: 1'b0};
      batch.insert(batch.size(), r);
    endfunction

    function void pop_closer(logic [31:0] limit);
      logic [31:0] c;
      c = closers[0];
      closers.delete(0);
      if (c > run_pos) begin
        add_run(run_pos, c, open_cnt, limit);
        run_pos = c;
      end
      if (open_cnt != 0) open_cnt--;
    endfunction

    function void note_word(logic act, logic [31:0] pos);
      logic [31:0] wstart;
      logic [32:0] wend;
      batch.delete();
      words++;
      if (act == ACT_SITE) begin
        wstart = (pos > half_width) ? pos - half_width : 32'd1;
        wend   = {1'b0, pos} + half_width + 33'd1;
        if (wend > 33'hFFFF_FFFF) wend = 33'hFFFF_FFFF;  // saturate window end
        while (closers.size() != 0 && closers[0] <= wstart) pop_closer(32'd0);
        if (wstart > run_pos) begin
          add_run(run_pos, wstart, open_cnt, 32'd0);
          run_pos = wstart;
        end
        if (closers.size() < CLOSER_DEPTH) begin
          closers.insert(closers.size(), wend[31:0]);
          open_cnt++;
        end else begin
          ovf_flag = 1'b1;   // site dropped
        end
      end else begin
        while (closers.size() != 0) pop_closer(chrom_len);
        if (chrom_len != 0 && run_pos < chrom_len)
          add_run(run_pos, chrom_len, 6'd0, chrom_len);
      end
      foreach (batch[i]) begin
        batch[i].ovf  = ovf_flag;
        batch[i].last = (i == batch.size() - 1);
        runs_due.insert(runs_due.size(), batch[i]);
      end
      if (act == ACT_FINISH) begin
        ovf_flag = 1'b0;
        clear_chrom();
      end
    endfunction

    function void check_run(logic [31:0] got_start, logic [31:0] got_stop,
                            logic [5:0] got_cov, logic got_last, logic got_ovf);
      run_rec_t want;
      runs_seen++;
      if (got_ovf) ovf_runs++;
      if (runs_due.size() == 0) begin
        $error("unexpected run: start %0d end %0d coverage %0d",
               got_start, got_stop, got_cov);
        errors++;
        return;
      end
      want = runs_due[0];
      runs_due.delete(0);
      if (got_start !== want.run_start) begin
        $error("run_start: expected %0d, got %0d", want.run_start, got_start);
        errors++;
      end
      if (got_stop !== want.run_end) begin
        $error("run_end: expected %0d, got %0d", want.run_end, got_stop);
        errors++;
      end
      if (got_cov !== want.coverage) begin
        $error("coverage: expected %0d, got %0d", want.coverage, got_cov);
        errors++;
      end
      if (got_last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got_last);
        errors++;
      end
      if (got_ovf !== want.ovf) begin
        $error("queue_overflow: expected %0d, got %0d", want.ovf, got_ovf);
        errors++;
      end
    endfunction
  endclass

  pileup_scoreboard sb = new();

  int send_idle_pct  = 0;   // sender idles this share of cycles
  int recv_stall_pct = 0;   // receiver stalls this share of cycles
  int hold_requests  = 0;   // bumped by stimulus, served by the receiver
  int holds_served   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  smoothed_site_coverage_runs DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Output side: check each accepted word, then pick next tready. A pending
  // hold request drops tready for a long stretch counted here.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_run(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[69:64],
                     m_axis_tlast, m_axis_tuser[0]);
      if (holds_served != hold_requests) begin
        holds_served <= hold_requests;
        hold_left    <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too long with nothing moving means a hang.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_smoothed_site_coverage_runs: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, with random idle cycles ahead of it; tvalid stays high
  // on return so back-to-back words need no extra step.
  task automatic send_word(input logic act, input logic [31:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= pos;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(act, pos);
  endtask

  // Sender pause until every expected run has come out.
  task automatic drain_runs();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.runs_due.size() != 0);
  endtask

  // Drained, then enough cycles for a word that yields no run to finish.
  task automatic settle();
    drain_runs();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] hw, input logic [31:0] chrom, input logic ez);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_WIDTH;
    cfg_data  <= {16'd0, hw};
    @(posedge clk);
    sb.set_reg(REG_HALF_WIDTH, {16'd0, hw});
    cfg_index <= REG_CHROM_SIZE;
    cfg_data  <= chrom;
    @(posedge clk);
    sb.set_reg(REG_CHROM_SIZE, chrom);
    cfg_index <= REG_EMIT_ZERO;
    cfg_data  <= {31'd0, ez};
    @(posedge clk);
    sb.set_reg(REG_EMIT_ZERO, {31'd0, ez});
    cfg_we <= 1'b0;
  endtask

  // One chromosome: mostly sorted sites with random spacing, sometimes a dense
  // burst that overruns the closer queue, sometimes unsorted noise. Always
  // closed by a finish word.
  task automatic random_chrom();
    int          kind, n, gap_max, hw;
    logic [31:0] p;
    logic [32:0] nxt;
    hw   = sb.half_width;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       p = $urandom_range(0, 60);
      1:       p = 32'hFFFF_FFFF - $urandom_range(0, 3000);   // near the top, where the window end can saturate
      default: p = $urandom;
    endcase
    if (kind < 12) begin
      // dense burst, 30 to 40 sites against 32 closer slots
      n = $urandom_range(30, 40);
      for (int i = 0; i < n; i++) begin
        send_word(ACT_SITE, p);
        nxt = {1'b0, p} + ((hw == 0) ? 0 : $urandom_range(0, 1));
        p   = (nxt > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
      end
    end else if (kind < 22) begin
      // unsorted noise, stray finish words included
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_word(logic'($urandom_range(0, 1)), $urandom);
    end else begin
      n       = $urandom_range(1, 14);
      gap_max = $urandom_range(0, 1) ? 2 * hw + 2 : 8 * hw + 50;
      for (int i = 0; i < n; i++) begin
        send_word(ACT_SITE, p);
        nxt = {1'b0, p} + $urandom_range(0, gap_max);
        p   = (nxt > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
      end
    end
    send_word(ACT_FINISH, $urandom);
  endtask

  initial begin
    logic [15:0] hw;
    logic [31:0] chrom;
    logic        ez;
    int          target;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // exact counts: site at 0 clamps to 1, duplicate, unsorted site
    configure(16'd0, 32'd0, 1'b1);
    send_word(ACT_SITE, 32'd0);
    send_word(ACT_SITE, 32'd1);
    send_word(ACT_SITE, 32'd1);
    send_word(ACT_SITE, 32'd5);
    send_word(ACT_SITE, 32'd3);
    send_word(ACT_FINISH, 32'd0);
    settle();
    // widest window at the top of the range: ends saturate, clamp drops
    // every finish run, then a finish on an empty chromosome
    configure(16'hFFFF, 32'd100000, 1'b0);
    send_word(ACT_SITE, 32'hFFFF_FFF0);
    send_word(ACT_SITE, 32'hFFFF_FFFF);
    send_word(ACT_FINISH, 32'hFFFF_FFFF);
    send_word(ACT_FINISH, 32'd0);
    settle();
    // zero mode with clamp: trailing zero run up to the chromosome end
    configure(16'd10, 32'd100, 1'b1);
    send_word(ACT_SITE, 32'd10);
    send_word(ACT_SITE, 32'd20);
    send_word(ACT_FINISH, 32'd0);
    settle();
    // clamp cuts the last window short, zero runs suppressed
    configure(16'd10, 32'd30, 1'b0);
    send_word(ACT_SITE, 32'd5);
    send_word(ACT_SITE, 32'd25);
    send_word(ACT_FINISH, 32'd0);
    settle();

    // ---- random: four idling phases, two register settings each ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int k = 0; k < 2; k++) begin
        case (2 * ph + k)
          0:       begin hw = 16'd0;     chrom = 32'd0;                    ez = 1'b0; end
          1:       begin hw = 16'hFFFF;  chrom = 32'hFFFF_FFFF;            ez = 1'b1; end
          2:       begin hw = 16'd3;     chrom = 32'd0;                    ez = 1'b1; end
          3:       begin hw = 16'd25;    chrom = $urandom_range(1, 5000);  ez = 1'b0; end
          4:       begin hw = 16'd200;   chrom = 32'd0;                    ez = 1'b0; end
          5:       begin hw = 16'd1;     chrom = $urandom;                 ez = 1'b1; end
          6:       begin hw = 16'd40000; chrom = 32'd0;                    ez = 1'b1; end
          default: begin
            hw = $urandom_range(0, 65535); chrom = $urandom; ez = $urandom_range(0, 1);
          end
        endcase
        configure(hw, chrom, ez);
        // output held off while input keeps coming: block fills and stalls
        if (k == 0 && (ph == 0 || ph == 2))
          hold_requests <= hold_requests + 1;
        target = sb.words + RANDOM_WORDS;
        while (sb.words < target) begin
          random_chrom();
          if (sb.words > target - RANDOM_WORDS / 2 && $urandom_range(0, 3) == 0)
            drain_runs();
        end
        settle();
      end
    end

    $display("coverage runs: %0d words in, %0d runs checked, %0d with overflow set;",
             sb.words, sb.runs_seen, sb.ovf_runs);
    $display("12 register settings, four idling phases, two long output holds");
    if (sb.errors == 0 && sb.runs_due.size() == 0) begin
      $display("tb_smoothed_site_coverage_runs: done, clean");
    end else begin
      $display("tb_smoothed_site_coverage_runs: done, errors");
    end
    $finish;
  end

endmodule
